FILE: src/tsg_pkg.sv
// Shared constants, field widths and types of the triangle span generator.
// Used by every module under src; depends on nothing.
`default_nettype none

package tsg_pkg;

    // Field and arithmetic widths
    localparam int COORD_BITS = 14;
    localparam int FRAC_BITS  = 16;
    localparam int COLOUR_BITS = 32;
    localparam int DW         = COORD_BITS + 1;          // coordinate difference width
    localparam int AW         = DW + FRAC_BITS;          // edge offset accumulator width
    localparam int CNT_W      = $clog2(FRAC_BITS);       // quotient bit counter width

    // Stream word widths
    localparam int IN_W        = 6 * COORD_BITS + COLOUR_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 3 * COORD_BITS + COLOUR_BITS;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH  = 2'd2;

    // Configuration reset values
    localparam logic signed [COORD_BITS-1:0] CLIP_TOP_RST  = COORD_BITS'(-4096);
    localparam logic [COORD_BITS-1:0]        CLIP_SIZE_RST = COORD_BITS'(8192);

    // Input item modes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // One vertex
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } vtx_t;

    // Edge interpolation request: edge from (xa,ya) to (xb,yb), evaluated at row y
    typedef struct packed {
        logic signed [COORD_BITS-1:0] xa;
        logic signed [COORD_BITS-1:0] ya;
        logic signed [COORD_BITS-1:0] xb;
        logic signed [COORD_BITS-1:0] yb;
        logic signed [COORD_BITS-1:0] y;
    } edge_req_t;

    // Edge interpolation response
    typedef struct packed {
        logic                         done;
        logic signed [COORD_BITS-1:0] x;
    } edge_rsp_t;

endpackage

`default_nettype wire

FILE: src/tsg_vertex_sort.sv
// Sorts three vertices by y with a stable tie order (a before b, c after equals).
// Depends on tsg_pkg.
`default_nettype none

module tsg_vertex_sort (
    input  tsg_pkg::vtx_t va,
    input  tsg_pkg::vtx_t vb,
    input  tsg_pkg::vtx_t vc,
    output tsg_pkg::vtx_t v0,
    output tsg_pkg::vtx_t v1,
    output tsg_pkg::vtx_t v2
);
    import tsg_pkg::*;

    vtx_t p0;
    vtx_t p1;

    // Order a and b, keeping a first on a tie
    always_comb
    begin
        if (vb.y < va.y)
        begin
            p0 = vb;
            p1 = va;
        end
        else
        begin
            p0 = va;
            p1 = vb;
        end
    end

    // Insert c after any vertex with an equal y
    always_comb
    begin
        if (vc.y < p0.y)
        begin
            v0 = vc;
            v1 = p0;
            v2 = p1;
        end
        else if (vc.y < p1.y)
        begin
            v0 = p0;
            v1 = vc;
            v2 = p1;
        end
        else
        begin
            v0 = p0;
            v1 = p1;
            v2 = vc;
        end
    end

endmodule

`default_nettype wire

FILE: src/tsg_edge_unit.sv
// Bit-serial edge interpolator: restoring division one quotient bit per cycle,
// with the quotient folded into dx * fraction MSB first. Depends on tsg_pkg.
`default_nettype none

module tsg_edge_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tsg_pkg::edge_req_t  req,
    output tsg_pkg::edge_rsp_t  rsp
);
    import tsg_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                done_reg;
    logic                done_next;

    logic [DW-1:0]       rem_reg;
    logic [DW-1:0]       den_reg;
    logic [DW-1:0]       dx_reg;
    logic [COORD_BITS-1:0] xa_reg;
    logic [AW-1:0]       acc_reg;

    logic [DW:0]         rem2;
    logic [DW:0]         rem_diff;
    logic                q_bit;
    logic [AW-1:0]       dx_ext;
    logic [DW-1:0]       x_sum;

    // One restoring division step per cycle
    assign rem2     = {rem_reg, 1'b0};
    assign rem_diff = rem2 - {1'b0, den_reg};
    assign q_bit    = (rem2 >= {1'b0, den_reg});
    assign dx_ext   = {{(AW-DW){dx_reg[DW-1]}}, dx_reg};

    // Control sequencing
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Load operands on start, then shift in one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {req.y[COORD_BITS-1], req.y} - {req.ya[COORD_BITS-1], req.ya};
            den_reg <= {req.yb[COORD_BITS-1], req.yb} - {req.ya[COORD_BITS-1], req.ya};
            dx_reg  <= {req.xb[COORD_BITS-1], req.xb} - {req.xa[COORD_BITS-1], req.xa};
            xa_reg  <= req.xa;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? rem_diff[DW-1:0] : rem2[DW-1:0];
            acc_reg <= {acc_reg[AW-2:0], 1'b0} + (q_bit ? dx_ext : '0);
        end
    end

    // Offset floors toward minus infinity by taking the upper bits
    assign x_sum    = {xa_reg[COORD_BITS-1], xa_reg} + acc_reg[AW-1:FRAC_BITS];
    assign rsp.x    = x_sum[COORD_BITS-1:0];
    assign rsp.done = done_reg;

endmodule

`default_nettype wire

FILE: src/triangle_scanline_span_generator.sv
// Top level of the triangle span generator: configuration, triangle setup,
// row sequencing and span output register. Depends on tsg_pkg,
// tsg_vertex_sort and tsg_edge_unit.
//
//  channel  | signals                               | moves
//  ---------+---------------------------------------+------------------------------
//  s        | s_tvalid s_tready s_tdata s_tuser     | load / advance word in
//  m        | m_tvalid m_tready m_tdata m_tlast     | span word out
//  cfg      | cfg_we cfg_index cfg_data             | clip register write
//
// A load word is accepted while idle and emits nothing. An advance word of a
// pending triangle is accepted, both edge units then form their quotient
// bits side by side, the sequencer sees both units done, and the span is
// registered once the output register is free, before the input opens again.
// Reset sets the clip registers to their defaults and leaves no triangle pending.
// A span waiting on m_tready stays in the output register while the next word
// is accepted; the following span then waits until the register frees up.
`default_nettype none

module triangle_scanline_span_generator (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    // fill_colour, zero pad
    input  logic [tsg_pkg::IN_TDATA_W-1:0] s_tdata,
    // mode
    input  logic                           s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // span_x, span_y, span_width, span_colour, zero pad
    output logic [tsg_pkg::OUT_TDATA_W-1:0] m_tdata,
    // last_span
    output logic                           m_tlast,

    input  logic                           cfg_we,
    input  logic [tsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsg_pkg::COORD_BITS-1:0] cfg_data
);
    import tsg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Clip registers
    logic signed [COORD_BITS-1:0] clip_top_reg;
    logic [COORD_BITS-1:0]        clip_height_reg;
    logic [COORD_BITS-1:0]        clip_width_reg;

    // Triangle state
    vtx_t                         vtx_reg [3];
    logic signed [COORD_BITS-1:0] cur_row_reg;
    logic signed [COORD_BITS-1:0] cur_row_next;
    logic signed [COORD_BITS-1:0] end_row_reg;
    logic [COLOUR_BITS-1:0]       colour_reg;
    logic                         active_reg;
    logic                         active_next;

    // Output register
    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic                         m_tlast_reg;
    logic signed [COORD_BITS-1:0] span_x_reg;
    logic signed [COORD_BITS-1:0] span_y_reg;
    logic [COORD_BITS-1:0]        span_w_reg;
    logic [COLOUR_BITS-1:0]       span_c_reg;

    logic                         in_fire;
    logic                         do_load;
    logic                         start_calc;
    logic                         out_load;

    vtx_t                         in_a;
    vtx_t                         in_b;
    vtx_t                         in_c;
    vtx_t                         srt0;
    vtx_t                         srt1;
    vtx_t                         srt2;

    logic signed [COORD_BITS-1:0] lo_row;
    logic signed [COORD_BITS-1:0] hi_row;
    logic signed [COORD_BITS+1:0] clip_bottom;
    logic                         load_active;

    edge_req_t                    lng_req;
    edge_req_t                    sht_req;
    edge_rsp_t                    lng_rsp;
    edge_rsp_t                    sht_rsp;

    logic signed [COORD_BITS-1:0] xl;
    logic signed [COORD_BITS-1:0] xs;
    logic signed [COORD_BITS-1:0] left_x;
    logic signed [COORD_BITS-1:0] right_x;
    logic [DW-1:0]                width_full;
    logic signed [DW-1:0]         row_inc;
    logic                         is_last;

    // Handshake
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign do_load    = in_fire && (s_tuser == MODE_LOAD);
    assign start_calc = in_fire && (s_tuser == MODE_ADVANCE) && active_reg;
    assign out_load   = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // Unpack vertices
    assign in_a.x = s_tdata[0*COORD_BITS +: COORD_BITS];
    assign in_a.y = s_tdata[1*COORD_BITS +: COORD_BITS];
    assign in_b.x = s_tdata[2*COORD_BITS +: COORD_BITS];
    assign in_b.y = s_tdata[3*COORD_BITS +: COORD_BITS];
    assign in_c.x = s_tdata[4*COORD_BITS +: COORD_BITS];
    assign in_c.y = s_tdata[5*COORD_BITS +: COORD_BITS];

    tsg_vertex_sort u_sort (
        .va (in_a),
        .vb (in_b),
        .vc (in_c),
        .v0 (srt0),
        .v1 (srt1),
        .v2 (srt2)
    );

    // Clip the row range; the bottom bound is formed at full width
    assign clip_bottom = {{2{clip_top_reg[COORD_BITS-1]}}, clip_top_reg}
                       + {2'b00, clip_height_reg};
    assign lo_row = (srt0.y < clip_top_reg) ? clip_top_reg : srt0.y;
    assign hi_row = ($signed({{2{srt2.y[COORD_BITS-1]}}, srt2.y}) > clip_bottom)
                  ? clip_bottom[COORD_BITS-1:0] : srt2.y;
    assign load_active = (clip_width_reg != '0) && (clip_height_reg != '0)
                       && (lo_row < hi_row);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_top_reg    <= CLIP_TOP_RST;
            clip_height_reg <= CLIP_SIZE_RST;
            clip_width_reg  <= CLIP_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data;
                REG_CLIP_HEIGHT: clip_height_reg <= cfg_data;
                REG_CLIP_WIDTH:  clip_width_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Edge requests: long edge top to bottom, short edge switches at the middle vertex
    always_comb
    begin
        lng_req.xa = vtx_reg[0].x;
        lng_req.ya = vtx_reg[0].y;
        lng_req.xb = vtx_reg[2].x;
        lng_req.yb = vtx_reg[2].y;
        lng_req.y  = cur_row_reg;
        sht_req.y  = cur_row_reg;
        if (cur_row_reg < vtx_reg[1].y)
        begin
            sht_req.xa = vtx_reg[0].x;
            sht_req.ya = vtx_reg[0].y;
            sht_req.xb = vtx_reg[1].x;
            sht_req.yb = vtx_reg[1].y;
        end
        else
        begin
            sht_req.xa = vtx_reg[1].x;
            sht_req.ya = vtx_reg[1].y;
            sht_req.xb = vtx_reg[2].x;
            sht_req.yb = vtx_reg[2].y;
        end
    end

    tsg_edge_unit u_long (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_calc),
        .req   (lng_req),
        .rsp   (lng_rsp)
    );

    tsg_edge_unit u_short (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_calc),
        .req   (sht_req),
        .rsp   (sht_rsp)
    );

    // Pick edge x values, vertex rows take the vertex x directly
    always_comb
    begin
        if (cur_row_reg == vtx_reg[0].y)
            xl = vtx_reg[0].x;
        else if (cur_row_reg == vtx_reg[2].y)
            xl = vtx_reg[2].x;
        else
            xl = lng_rsp.x;

        if (cur_row_reg == vtx_reg[0].y)
            xs = vtx_reg[0].x;
        else if (cur_row_reg < vtx_reg[1].y)
            xs = sht_rsp.x;
        else if (cur_row_reg == vtx_reg[1].y)
            xs = vtx_reg[1].x;
        else if (cur_row_reg < vtx_reg[2].y)
            xs = sht_rsp.x;
        else
            xs = vtx_reg[2].x;
    end

    assign left_x     = (xl < xs) ? xl : xs;
    assign right_x    = (xl < xs) ? xs : xl;
    assign width_full = {right_x[COORD_BITS-1], right_x} - {left_x[COORD_BITS-1], left_x};
    assign row_inc    = {cur_row_reg[COORD_BITS-1], cur_row_reg} + DW'(1);
    assign is_last    = (row_inc >= $signed({end_row_reg[COORD_BITS-1], end_row_reg}));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_calc)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (lng_rsp.done && sht_rsp.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Triangle activity and output valid
    always_comb
    begin
        active_next   = active_reg;
        m_tvalid_next = m_tvalid_reg;
        if (do_load)
            active_next = load_active;
        else if (out_load && is_last)
            active_next = 1'b0;
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold triangle setup and advance the row
    always_comb
    begin
        cur_row_next = cur_row_reg;
        if (do_load)
            cur_row_next = lo_row;
        else if (out_load)
            cur_row_next = row_inc[COORD_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg <= cur_row_next;
        if (do_load)
        begin
            vtx_reg[0]  <= srt0;
            vtx_reg[1]  <= srt1;
            vtx_reg[2]  <= srt2;
            end_row_reg <= hi_row;
            colour_reg  <= s_tdata[6*COORD_BITS +: COLOUR_BITS];
        end
    end

    // Output span register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            span_x_reg  <= left_x;
            span_y_reg  <= cur_row_reg;
            span_w_reg  <= width_full[COORD_BITS-1:0];
            span_c_reg  <= colour_reg;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, span_c_reg, span_w_reg,
                       span_y_reg, span_x_reg};

    // Checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("span register overwritten while held");

    a_calc_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (active_reg && (cur_row_reg < end_row_reg)))
        else $error("edge calculation outside the pending row range");

    a_units_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        lng_rsp.done == sht_rsp.done)
        else $error("edge units out of step");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("span word raised outside emit");

endmodule

`default_nettype wire
